FILE: rtl/lzwd_pkg.sv
// Package for the LZW code decoder.
// Holds the item types, fixed widths and the sequencer state type.
// No dependencies.
package lzwd_pkg;

    localparam int CODE_W     = 9;
    localparam int BYTE_W     = 8;
    localparam int CHUNK_W    = 64;
    localparam int COUNT_W    = 4;
    localparam int LANES      = CHUNK_W / BYTE_W;
    localparam int LITERALS   = 256;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              stream_start;
    } code_item_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk;
        logic [COUNT_W-1:0] byte_count;
        logic               last_chunk;
    } chunk_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHASE,
        ST_FETCH,
        ST_GATHER,
        ST_DELIVER
    } lzwd_state_t;

endpackage

FILE: rtl/lzwd_dict.sv
// Dictionary memories of the LZW code decoder: prefix code and suffix byte per entry.
// One write port and one read port with registered read data.
// Depends on lzwd_pkg.
module lzwd_dict #(
    parameter int CODE_BITS = 9
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [CODE_BITS-1:0]      wr_addr,
    input  logic [CODE_BITS-1:0]      wr_prefix,
    input  logic [lzwd_pkg::BYTE_W-1:0] wr_suffix,
    input  logic [CODE_BITS-1:0]      rd_addr,
    output logic [CODE_BITS-1:0]      rd_prefix,
    output logic [lzwd_pkg::BYTE_W-1:0] rd_suffix
);

    localparam int DICT_SIZE = 1 << CODE_BITS;

    logic [CODE_BITS-1:0]        prefix_mem [DICT_SIZE];
    logic [lzwd_pkg::BYTE_W-1:0] suffix_mem [DICT_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prefix_mem[wr_addr] <= wr_prefix;
            suffix_mem[wr_addr] <= wr_suffix;
        end
        rd_prefix <= prefix_mem[rd_addr];
        rd_suffix <= suffix_mem[rd_addr];
    end

endmodule

FILE: rtl/lzwd_stack.sv
// Expansion stack of the LZW code decoder: reverses the bytes of one decoded string.
// One write port and one read port with registered read data.
// Depends on lzwd_pkg.
module lzwd_stack #(
    parameter int CODE_BITS = 9
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [CODE_BITS-1:0]        wr_addr,
    input  logic [lzwd_pkg::BYTE_W-1:0] wr_data,
    input  logic [CODE_BITS-1:0]        rd_addr,
    output logic [lzwd_pkg::BYTE_W-1:0] rd_data
);

    localparam int DEPTH = (1 << CODE_BITS) - 255;

    logic [lzwd_pkg::BYTE_W-1:0] stack_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data <= stack_mem[rd_addr];
    end

endmodule

FILE: rtl/lzw_code_decoder.sv
// LZW code decoder: one code per item in, the decoded string out in chunks.
// Steps: a stream start code goes straight to delivery of its single byte; any other
// code first walks its prefix chain onto the stack (for a code not yet defined, the
// first byte of the previous string is pushed at accept), then each chunk is fetched,
// gathered from bytes popped off the stack and delivered, waiting on chunk_ready.
// One code at a time; rst_n clears control state, dictionary and stack are not cleared.
module lzw_code_decoder #(
    parameter int CHUNK_BYTES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  code_valid,
    output logic                  code_ready,
    input  lzwd_pkg::code_item_t  code_item,
    output logic                  chunk_valid,
    input  logic                  chunk_ready,
    output lzwd_pkg::chunk_item_t chunk_item
);

    localparam int CODE_BITS = lzwd_pkg::CODE_W;
    localparam int NFC_W     = CODE_BITS + 1;
    localparam int BW        = lzwd_pkg::BYTE_W;
    localparam int CW        = lzwd_pkg::COUNT_W;

    lzwd_pkg::lzwd_state_t state_reg, state_next;
    logic [CODE_BITS-1:0]  cur_reg, cur_next;
    logic [CODE_BITS-1:0]  new_code_reg, new_code_next;
    logic [CODE_BITS-1:0]  prev_code_reg, prev_code_next;
    logic [BW-1:0]         prev_first_reg, prev_first_next;
    logic [NFC_W-1:0]      nfc_reg, nfc_next;
    logic [CODE_BITS-1:0]  sp_reg, sp_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [lzwd_pkg::CHUNK_W-1:0] asm_reg, asm_next;
    lzwd_pkg::chunk_item_t out_reg;
    logic                  out_valid_reg;
    logic                  out_load;

    logic                  dict_wr_en;
    logic [CODE_BITS-1:0]  dict_rd_addr;
    logic [CODE_BITS-1:0]  dict_prefix_q;
    logic [BW-1:0]         dict_suffix_q;
    logic                  stk_wr_en;
    logic [CODE_BITS-1:0]  stk_wr_addr;
    logic [BW-1:0]         stk_wr_data;
    logic [CODE_BITS-1:0]  stk_rd_addr;
    logic [BW-1:0]         stk_q;

    logic [CODE_BITS-1:0]  code_ext;
    logic                  code_defined;
    logic                  cur_literal;
    logic                  out_free;

    assign code_ext     = CODE_BITS'(code_item.code);
    assign code_defined = {1'b0, code_ext} < nfc_reg;
    assign cur_literal  = (cur_reg >> 8) == '0;
    assign out_free     = !out_valid_reg || chunk_ready;

    lzwd_dict #(.CODE_BITS(CODE_BITS)) u_dict (
        .clk       (clk),
        .wr_en     (dict_wr_en),
        .wr_addr   (nfc_reg[CODE_BITS-1:0]),
        .wr_prefix (prev_code_reg),
        .wr_suffix (cur_reg[BW-1:0]),
        .rd_addr   (dict_rd_addr),
        .rd_prefix (dict_prefix_q),
        .rd_suffix (dict_suffix_q)
    );

    lzwd_stack #(.CODE_BITS(CODE_BITS)) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lzwd_pkg::ST_IDLE;
            nfc_reg        <= NFC_W'(lzwd_pkg::LITERALS);
            prev_code_reg  <= '0;
            prev_first_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nfc_reg        <= nfc_next;
            prev_code_reg  <= prev_code_next;
            prev_first_reg <= prev_first_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chunk_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        new_code_reg <= new_code_next;
        sp_reg       <= sp_next;
        cnt_reg      <= cnt_next;
        asm_reg      <= asm_next;
        if (out_load)
        begin
            out_reg.chunk      <= asm_reg;
            out_reg.byte_count <= cnt_reg;
            out_reg.last_chunk <= (sp_reg == '0);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        new_code_next   = new_code_reg;
        prev_code_next  = prev_code_reg;
        prev_first_next = prev_first_reg;
        nfc_next        = nfc_reg;
        sp_next         = sp_reg;
        cnt_next        = cnt_reg;
        asm_next        = asm_reg;
        out_load        = 1'b0;
        code_ready      = 1'b0;
        dict_wr_en      = 1'b0;
        dict_rd_addr    = cur_reg;
        stk_wr_en       = 1'b0;
        stk_wr_addr     = sp_reg;
        stk_wr_data     = cur_reg[BW-1:0];
        stk_rd_addr     = sp_reg - 1'b1;

        case (state_reg)
            lzwd_pkg::ST_IDLE:
            begin
                code_ready = 1'b1;
                if (code_item.stream_start || code_defined)
                begin
                    dict_rd_addr = code_ext;
                end
                else
                begin
                    dict_rd_addr = prev_code_reg;
                end
                if (code_valid)
                begin
                    if (code_item.stream_start)
                    begin
                        nfc_next        = NFC_W'(lzwd_pkg::LITERALS);
                        prev_code_next  = CODE_BITS'(code_item.code[BW-1:0]);
                        prev_first_next = code_item.code[BW-1:0];
                        asm_next        = lzwd_pkg::CHUNK_W'(code_item.code[BW-1:0]);
                        cnt_next        = CW'(1);
                        sp_next         = '0;
                        state_next      = lzwd_pkg::ST_DELIVER;
                    end
                    else if (code_defined)
                    begin
                        cur_next      = code_ext;
                        new_code_next = code_ext;
                        sp_next       = '0;
                        state_next    = lzwd_pkg::ST_CHASE;
                    end
                    else
                    begin
                        stk_wr_en     = 1'b1;
                        stk_wr_addr   = '0;
                        stk_wr_data   = prev_first_reg;
                        cur_next      = prev_code_reg;
                        new_code_next = nfc_reg[CODE_BITS-1:0];
                        sp_next       = CODE_BITS'(1);
                        state_next    = lzwd_pkg::ST_CHASE;
                    end
                end
            end

            lzwd_pkg::ST_CHASE:
            begin
                stk_wr_en = 1'b1;
                sp_next   = sp_reg + 1'b1;
                if (!cur_literal)
                begin
                    stk_wr_data  = dict_suffix_q;
                    dict_rd_addr = dict_prefix_q;
                    cur_next     = dict_prefix_q;
                end
                else
                begin
                    stk_wr_data     = cur_reg[BW-1:0];
                    prev_code_next  = new_code_reg;
                    prev_first_next = cur_reg[BW-1:0];
                    if (!nfc_reg[CODE_BITS])
                    begin
                        dict_wr_en = 1'b1;
                        nfc_next   = nfc_reg + 1'b1;
                    end
                    state_next = lzwd_pkg::ST_FETCH;
                end
            end

            lzwd_pkg::ST_FETCH:
            begin
                sp_next    = sp_reg - 1'b1;
                cnt_next   = '0;
                asm_next   = '0;
                state_next = lzwd_pkg::ST_GATHER;
            end

            lzwd_pkg::ST_GATHER:
            begin
                for (int i = 0; i < lzwd_pkg::LANES; i++)
                begin
                    if (i < CHUNK_BYTES && cnt_reg == CW'(i))
                    begin
                        asm_next[BW*i +: BW] = stk_q;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_next == CW'(CHUNK_BYTES) || sp_reg == '0)
                begin
                    state_next = lzwd_pkg::ST_DELIVER;
                end
                else
                begin
                    sp_next = sp_reg - 1'b1;
                end
            end

            lzwd_pkg::ST_DELIVER:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (sp_reg == '0)
                    begin
                        state_next = lzwd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lzwd_pkg::ST_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = lzwd_pkg::ST_IDLE;
            end
        endcase
    end

    assign chunk_valid = out_valid_reg;
    assign chunk_item  = out_reg;

endmodule

FILE: rtl/lzwd_checker.sv
// Port-level checker for the LZW code decoder, bound to the top level.
// Depends on lzwd_pkg and the ports of lzw_code_decoder.
module lzwd_checker #(
    parameter int CHUNK_BYTES = 8
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  code_valid,
    input logic                  code_ready,
    input logic                  chunk_valid,
    input logic                  chunk_ready,
    input lzwd_pkg::chunk_item_t chunk_item
);

    a_chunk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && !chunk_ready |=> chunk_valid && $stable(chunk_item))
        else $error("Chunk item changed or dropped while stalled.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid |-> chunk_item.byte_count != '0 &&
                        chunk_item.byte_count <= lzwd_pkg::COUNT_W'(CHUNK_BYTES))
        else $error("Chunk byte count out of range.");

    a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && !chunk_item.last_chunk |->
            chunk_item.byte_count == lzwd_pkg::COUNT_W'(CHUNK_BYTES))
        else $error("A chunk that is not the last one is not full.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_ready |=> !code_ready)
        else $error("Decoder took a code item while still decoding the previous one.");

endmodule

bind lzw_code_decoder lzwd_checker #(.CHUNK_BYTES(CHUNK_BYTES)) u_lzwd_checker (.*);

FILE: tb/sv/lzw_chunk_checker.sv
// Checker for the LZW code decoder: watches both channels, predicts the decoded chunks
// of every accepted code and compares them with the chunks the block delivers.
// Depends on lzwd_pkg for the item types and widths.
module lzw_chunk_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  code_valid,
    input  logic                  code_ready,
    input  lzwd_pkg::code_item_t  code_item,
    input  logic                  chunk_valid,
    input  logic                  chunk_ready,
    input  lzwd_pkg::chunk_item_t chunk_item,
    output int                    pending,
    output int                    fails
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_W     = lzwd_pkg::CODE_W;
    localparam int BYTE_W     = lzwd_pkg::BYTE_W;
    localparam int COUNT_W    = lzwd_pkg::COUNT_W;
    localparam int LANES      = lzwd_pkg::LANES;
    localparam int LITERALS   = lzwd_pkg::LITERALS;
    localparam int DICT_SIZE  = 1 << CODE_W;
    localparam int STACK_SIZE = DICT_SIZE - 255;

    logic [CODE_W-1:0]     prefix_of [DICT_SIZE];
    logic [BYTE_W-1:0]     suffix_of [DICT_SIZE];
    logic [BYTE_W-1:0]     byte_stack [STACK_SIZE];
    int unsigned           next_code;
    logic [CODE_W-1:0]     last_code;
    logic [BYTE_W-1:0]     last_first;
    lzwd_pkg::chunk_item_t expected_chunks [$];
    int                    mismatch_total = 0;

    function automatic void clear_dictionary();
        for (int i = 0; i < DICT_SIZE; i++)
        begin
            prefix_of[i] = '0;
            suffix_of[i] = '0;
        end
        for (int i = 0; i < STACK_SIZE; i++)
        begin
            byte_stack[i] = '0;
        end
        next_code  = LITERALS;
        last_code  = '0;
        last_first = '0;
    endfunction

    function automatic int unsigned push_chain(input int unsigned c, input int unsigned depth);
        while (c >= LITERALS && depth < STACK_SIZE - 1)
        begin
            byte_stack[depth] = suffix_of[c];
            depth++;
            c = 32'(prefix_of[c]);
        end
        if (depth < STACK_SIZE)
        begin
            byte_stack[depth] = 8'(c);
            depth++;
        end
        return depth;
    endfunction

    function automatic void decode_code(input lzwd_pkg::code_item_t it);
        int unsigned           c;
        int unsigned           depth;
        int unsigned           pos;
        int unsigned           cnt;
        logic [BYTE_W-1:0]     first;
        lzwd_pkg::chunk_item_t want;

        if (it.stream_start)
        begin
            next_code     = LITERALS;
            byte_stack[0] = it.code[BYTE_W-1:0];
            last_code     = CODE_W'(it.code[BYTE_W-1:0]);
            last_first    = it.code[BYTE_W-1:0];
            depth         = 1;
        end
        else
        begin
            c = 32'(it.code);
            if (c < next_code)
            begin
                depth = push_chain(c, 0);
                first = byte_stack[depth-1];
            end
            else
            begin
                byte_stack[0] = last_first;
                depth = push_chain(32'(last_code), 1);
                first = byte_stack[depth-1];
                c = next_code % DICT_SIZE;
            end
            if (next_code < DICT_SIZE)
            begin
                prefix_of[next_code] = last_code;
                suffix_of[next_code] = first;
                next_code++;
            end
            last_code  = CODE_W'(c);
            last_first = first;
        end

        pos = depth;
        while (pos > 0)
        begin
            want = '0;
            cnt  = 0;
            while (cnt < LANES && pos > 0)
            begin
                pos--;
                want.chunk[BYTE_W*cnt +: BYTE_W] = byte_stack[pos];
                cnt++;
            end
            want.byte_count = COUNT_W'(cnt);
            want.last_chunk = (pos == 0);
            expected_chunks.push_back(want);
        end
    endfunction

    always @(posedge clk)
    begin
        lzwd_pkg::chunk_item_t want;

        if (!rst_n)
        begin
            clear_dictionary();
            expected_chunks.delete();
        end
        else
        begin
            if (code_valid && code_ready)
            begin
                decode_code(code_item);
            end
            if (chunk_valid && chunk_ready)
            begin
                if (expected_chunks.size() == 0)
                begin
                    mismatch_total++;
                    $display("%0t: unexpected chunk item, expected none, got %h",
                             $time, chunk_item);
                end
                else
                begin
                    want = expected_chunks.pop_front();
                    if (chunk_item !== want)
                    begin
                        mismatch_total++;
                        if (chunk_item.chunk !== want.chunk)
                        begin
                            $display("%0t: chunk expected %h, got %h",
                                     $time, want.chunk, chunk_item.chunk);
                        end
                        if (chunk_item.byte_count !== want.byte_count)
                        begin
                            $display("%0t: byte_count expected %0d, got %0d",
                                     $time, want.byte_count, chunk_item.byte_count);
                        end
                        if (chunk_item.last_chunk !== want.last_chunk)
                        begin
                            $display("%0t: last_chunk expected %b, got %b",
                                     $time, want.last_chunk, chunk_item.last_chunk);
                        end
                    end
                end
            end
        end
        pending <= expected_chunks.size();
        fails   <= mismatch_total;
    end

endmodule

FILE: tb/sv/tb_lzw_code_decoder.sv
// Testbench top for the LZW code decoder: clock, reset, code stimulus and chunk stalls.
// Directed codes first, then random streams that grow the dictionary and break it up.
// Depends on lzwd_pkg, lzw_code_decoder and lzw_chunk_checker.
module tb_lzw_code_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_W      = lzwd_pkg::CODE_W;
    localparam int LITERALS    = lzwd_pkg::LITERALS;
    localparam int DICT_SIZE   = 1 << CODE_W;
    localparam int QUIET_LIMIT = 4000;
    localparam int ITEM_TARGET = 120;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  code_valid  = 1'b0;
    logic                  code_ready;
    lzwd_pkg::code_item_t  code_item   = '0;
    logic                  chunk_valid;
    logic                  chunk_ready = 1'b0;
    lzwd_pkg::chunk_item_t chunk_item;

    int pending;
    int fails;
    int quiet_cycles = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    int dict_fill    = LITERALS;
    int stall_left   = 0;
    int cycle_no     = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    lzw_code_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_valid  (code_valid),
        .code_ready  (code_ready),
        .code_item   (code_item),
        .chunk_valid (chunk_valid),
        .chunk_ready (chunk_ready),
        .chunk_item  (chunk_item)
    );

    lzw_chunk_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_valid  (code_valid),
        .code_ready  (code_ready),
        .code_item   (code_item),
        .chunk_valid (chunk_valid),
        .chunk_ready (chunk_ready),
        .chunk_item  (chunk_item),
        .pending     (pending),
        .fails       (fails)
    );

    always @(posedge clk)
    begin
        cycle_no++;
        if (stall_left > 0)
        begin
            chunk_ready <= 1'b0;
            stall_left--;
        end
        else if ((cycle_no / 500) % 3 != 0 && $urandom_range(0, 6) == 0)
        begin
            chunk_ready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end
        else
        begin
            chunk_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (code_valid && code_ready) || (chunk_valid && chunk_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_code(input logic [CODE_W-1:0] c, input logic start);
        lzwd_pkg::code_item_t it;
        int                   gap;

        it.code         = c;
        it.stream_start = start;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                code_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        code_valid <= 1'b1;
        code_item  <= it;
        @(posedge clk);
        while (!code_ready) @(posedge clk);
        burst_left--;
        items_sent++;
        if (start)
        begin
            dict_fill = LITERALS;
        end
        else if (dict_fill < DICT_SIZE)
        begin
            dict_fill++;
        end
    endtask

    task automatic wait_drained();
        code_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        int last_def;

        r = $urandom_range(0, 99);
        last_def = dict_fill - 1;
        if (r < 40)
        begin
            return CODE_W'(last_def - $urandom_range(0, 7));
        end
        if (r < 55 && dict_fill < DICT_SIZE)
        begin
            return CODE_W'(dict_fill);
        end
        if (r < 60)
        begin
            if (dict_fill < DICT_SIZE - 1)
            begin
                return CODE_W'($urandom_range(dict_fill + 1, DICT_SIZE - 1));
            end
            return CODE_W'($urandom_range(0, DICT_SIZE - 1));
        end
        return CODE_W'($urandom_range(0, last_def));
    endfunction

    task automatic run_stream(input int len, input logic allow_broken);
        int r;

        r = allow_broken ? $urandom_range(0, 9) : 9;
        if (r == 1)
        begin
            send_code(CODE_W'($urandom_range(LITERALS, DICT_SIZE - 1)), 1'b1);
        end
        else if (r != 0)
        begin
            send_code(CODE_W'($urandom_range(0, LITERALS - 1)), 1'b1);
        end
        for (int k = 1; k < len; k++)
        begin
            send_code(pick_code(), 1'b0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_code(9'h041, 1'b0);
        send_code(9'h100, 1'b0);
        send_code(9'h1FF, 1'b0);
        send_code(9'h1AA, 1'b1);
        send_code(9'h000, 1'b1);
        send_code(9'h0FF, 1'b0);
        send_code(9'h101, 1'b0);
        send_code(9'h101, 1'b0);
        send_code(9'h102, 1'b0);
        send_code(9'h103, 1'b0);
        send_code(9'h1FF, 1'b1);
        send_code(9'h155, 1'b0);
        send_code(9'h0AA, 1'b0);
        send_code(9'h100, 1'b0);
        send_code(9'h000, 1'b1);
        send_code(9'h000, 1'b0);
        wait_drained();

        run_stream(50, 1'b0);
        while (items_sent < ITEM_TARGET)
        begin
            run_stream($urandom_range(1, 16), 1'b1);
            if ($urandom_range(0, 3) == 0)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (fails == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
